### rtl/rptl_pkg.sv
// ---------------------------------------------------------------------------
// rptl_pkg: shared types and codes for the route pattern table lookup.
// Holds action codes, the path skip constant and the query sequencer state type.
// ---------------------------------------------------------------------------
package rptl_pkg;

	localparam logic [1:0] ACT_ENTRY = 2'd0;
	localparam logic [1:0] ACT_CHAIN = 2'd1;
	localparam logic [1:0] ACT_PATH  = 2'd2;
	localparam logic [1:0] ACT_QUERY = 2'd3;

	localparam int PathSkip = 2;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_PATH  = 9'b000000010,
		ST_BREQ  = 9'b000000100,
		ST_BCMP  = 9'b000001000,
		ST_BACK  = 9'b000010000,
		ST_SCAN  = 9'b000100000,
		ST_CREQ  = 9'b001000000,
		ST_CCMP  = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

endpackage

### rtl/route_pattern_table_lookup.sv
// ---------------------------------------------------------------------------
// route_pattern_table_lookup: sorted route pattern table with query search.
//
// Input words arrive on s_axis (tvalid/tready/tdata/tuser). tuser carries the
// action: write an entry, write a chain node, write a path node, or query.
// Writes take effect on acceptance and give no result. A query gives exactly one
// result word on m_axis: found, alp_read_id and matched_count.
// A query runs on one sequencer that owns a single 63-bit key comparator and
// the one read port of each store. It fetches path[0] and path[1], runs a
// binary search (about log2 of the entry count probes), scans backward over
// equal entries, then scans forward over the entries, comparing the chain
// nodes of each candidate, and hands the result to the output register.
// s_axis_tready is low from the acceptance of a query until its result is
// loaded into the output register. When the receiver stalls, that register
// holds the result and the input stays open; a following query runs and its
// result waits in the sequencer until the register has been emptied.
// Reset (arst_n low) returns the sequencer to idle and entry_count to zero.
// The stores have no reset; entries must be written before they are read.
// ---------------------------------------------------------------------------
module route_pattern_table_lookup
	import rptl_pkg::*;
#(
	parameter int ENTRIES    = 1024,
	parameter int NODE_WORDS = 4096,
	parameter int PATH_MAX   = 64,
	parameter int CHAIN_MAX  = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [10:0]  cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// index[11:0], rtb[42:12], start_node[74:43], prev_node[106:75],
	// chain_length[111:107], chain_base[123:112], alp_id[154:124],
	// node_id[186:155], path_length[193:187], zero fill to 200
	input  logic [199:0] s_axis_tdata,
	// action[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// found[0], alp_read_id[31:1], matched_count[36:32], zero fill to 40
	output logic [39:0]  m_axis_tdata
);

	localparam int EW = $clog2(ENTRIES);
	localparam int NW = $clog2(NODE_WORDS);
	localparam int PW = $clog2(PATH_MAX);
	localparam int CW = $clog2(CHAIN_MAX + 1);

	logic [11:0] in_index;
	logic [30:0] in_rtb;
	logic [31:0] in_start, in_prev, in_node, in_alp;
	logic [4:0]  in_clen;
	logic [11:0] in_cbase;
	logic [6:0]  in_plen;
	assign in_index = s_axis_tdata[11:0];
	assign in_rtb   = s_axis_tdata[42:12];
	assign in_start = s_axis_tdata[74:43];
	assign in_prev  = s_axis_tdata[106:75];
	assign in_clen  = s_axis_tdata[111:107];
	assign in_cbase = s_axis_tdata[123:112];
	assign in_alp   = {1'b0, s_axis_tdata[154:124]};
	assign in_node  = s_axis_tdata[186:155];
	assign in_plen  = s_axis_tdata[193:187];

	// Table entry: rtb, start node, prev node, id, chain base, chain length.
	typedef struct packed {
		logic [30:0] rtb;
		logic [31:0] start;
		logic [31:0] prev;
		logic [30:0] alp;
		logic [11:0] base;
		logic [CW-1:0] len;
	} entry_t;

	entry_t      entry_mem [ENTRIES];
	logic [31:0] node_mem  [NODE_WORDS];
	logic [31:0] path_mem  [PATH_MAX];

	state_t state_q;
	logic [10:0] count_q;
	logic        s_acc;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc = s_axis_tvalid && s_axis_tready;

	// Clamped chain length on write.
	logic [CW-1:0] wr_len;
	always_comb begin
		if (32'(in_clen) > 32'(CHAIN_MAX)) wr_len = CW'(CHAIN_MAX);
		else wr_len = CW'(in_clen);
	end

	// Read address registers and registered read data.
	logic [EW-1:0] e_addr;
	logic [NW-1:0] n_addr;
	logic [PW-1:0] p_addr;
	entry_t        e_rd_q;
	logic [31:0]   n_rd_q, p_rd_q;

	always_ff @(posedge clk) begin
		if (s_acc && s_axis_tuser == ACT_ENTRY && 32'(in_index) < ENTRIES)
			entry_mem[in_index[EW-1:0]] <= '{in_rtb, in_start, in_prev,
				in_alp[30:0], in_cbase, wr_len};
		if (s_acc && s_axis_tuser == ACT_CHAIN && 32'(in_index) < NODE_WORDS)
			node_mem[in_index[NW-1:0]] <= in_node;
		if (s_acc && s_axis_tuser == ACT_PATH && 32'(in_index) < PATH_MAX)
			path_mem[in_index[PW-1:0]] <= in_node;
		e_rd_q <= entry_mem[e_addr];
		n_rd_q <= node_mem[n_addr];
		p_rd_q <= path_mem[p_addr];
	end

	// Query working registers. Signed 18-bit indices cover up to 65536 entries.
	logic signed [17:0] lo_q, hi_q, mid_q, pos_q, n_q;
	logic [30:0]   rtb_q;
	logic [31:0]   p0_q, p1_q;
	logic [10:0]   plen_q;
	logic [CW-1:0] k_q;
	logic          ppos_q;
	logic          found_q, out_v_q;
	logic [30:0]   alp_q;
	logic [4:0]    mcnt_q;

	// Output register, loaded when the sequencer hands over a result.
	logic          res_found_q;
	logic [30:0]   res_alp_q;
	logic [4:0]    res_mcnt_q;

	logic signed [17:0] mid_c;
	assign mid_c = (lo_q + hi_q) >>> 1;

	// The shared comparator: table key against the query key.
	logic key_lt, key_eq, rtb_eq;
	assign rtb_eq = (e_rd_q.rtb == rtb_q);
	assign key_eq = rtb_eq && (e_rd_q.start == p0_q);
	assign key_lt = {e_rd_q.rtb, e_rd_q.start} < {rtb_q, p0_q};

	always_comb begin
		e_addr = EW'(pos_q);
		n_addr = NW'(32'(e_rd_q.base) + 32'(k_q));
		p_addr = PW'(32'(k_q) + PathSkip);
		unique case (state_q)
			ST_PATH: p_addr = PW'(ppos_q);
			ST_BREQ: e_addr = EW'(mid_c);
			ST_SCAN: e_addr = EW'(mid_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			out_v_q <= 1'b0;
			lo_q <= '0;
			hi_q <= '0;
			mid_q <= '0;
			pos_q <= '0;
			n_q <= '0;
			rtb_q <= '0;
			p0_q <= '0;
			p1_q <= '0;
			plen_q <= '0;
			k_q <= '0;
			ppos_q <= 1'b0;
			found_q <= 1'b0;
			alp_q <= '0;
			mcnt_q <= '0;
			res_found_q <= 1'b0;
			res_alp_q <= '0;
			res_mcnt_q <= '0;
		end else begin
			if (cfg_we) count_q <= cfg_wdata;
			if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					// Query setup; only the word that is accepted matters.
					rtb_q <= in_rtb;
					plen_q <= (32'(in_plen) > PATH_MAX) ? 11'(PATH_MAX) : 11'(in_plen);
					n_q <= (32'(count_q) > ENTRIES) ? 18'(ENTRIES) : 18'(count_q);
					lo_q <= '0;
					hi_q <= ((32'(count_q) > ENTRIES) ? 18'(ENTRIES) : 18'(count_q))
						- 18'sd1;
					ppos_q <= 1'b0;
					found_q <= 1'b0;
					alp_q <= '0;
					mcnt_q <= '0;
					if (s_acc && s_axis_tuser == ACT_QUERY) begin
						state_q <= ST_PATH;
					end
				end
				ST_PATH: begin
					// Read path[0] then path[1]; each read's data lands in the next cycle.
					ppos_q <= 1'b1;
					if (ppos_q) begin
						p0_q <= p_rd_q;
						state_q <= ST_BREQ;
					end
				end
				ST_BREQ: begin
					if (ppos_q) p1_q <= p_rd_q;
					ppos_q <= 1'b0;
					if (lo_q > hi_q) state_q <= ST_OUT;
					else begin
						mid_q <= mid_c;
						state_q <= ST_BCMP;
					end
				end
				ST_BCMP: begin
					if (key_lt) begin
						lo_q <= mid_q + 18'sd1;
						state_q <= ST_BREQ;
					end else if (!key_eq) begin
						hi_q <= mid_q - 18'sd1;
						state_q <= ST_BREQ;
					end else if (mid_q == 0) begin
						state_q <= ST_SCAN;
					end else begin
						pos_q <= mid_q - 18'sd1;
						state_q <= ST_BACK;
					end
				end
				ST_BACK: begin
					// Data of pos_q arrives next cycle; pos_q read in this state.
					state_q <= ST_CREQ;
					k_q <= '1;
				end
				ST_CREQ: begin
					if (k_q == '1) begin
						// Backward check of entry pos_q.
						if (key_eq) begin
							mid_q <= pos_q;
							if (pos_q == 0) begin
								k_q <= '0;
								state_q <= ST_SCAN;
							end else begin
								pos_q <= pos_q - 18'sd1;
								state_q <= ST_BACK;
							end
						end else begin
							k_q <= '0;
							state_q <= ST_SCAN;
						end
					end else begin
						state_q <= ST_CCMP;
					end
				end
				ST_SCAN: begin
					// Issue read of entry mid_q as the scan position.
					pos_q <= mid_q;
					k_q <= '0;
					if (mid_q >= n_q) state_q <= ST_OUT;
					else state_q <= ST_CCMP;
				end
				ST_CCMP: begin
					if (k_q == '0 && !ppos_q) begin
						// Entry data valid now.
						if (!rtb_eq) begin
							state_q <= ST_OUT;
						end else if (!key_eq || e_rd_q.prev != p1_q || e_rd_q.len == 0) begin
							mid_q <= mid_q + 18'sd1;
							state_q <= ST_SCAN;
						end else begin
							ppos_q <= 1'b1;
							state_q <= ST_CREQ;
						end
					end else begin
						// Node and path data for chain node k_q valid now.
						if (32'(k_q) + PathSkip >= 32'(plen_q) || n_rd_q != p_rd_q) begin
							ppos_q <= 1'b0;
							mid_q <= mid_q + 18'sd1;
							state_q <= ST_SCAN;
						end else if (k_q == e_rd_q.len - CW'(1)) begin
							found_q <= 1'b1;
							alp_q <= e_rd_q.alp;
							mcnt_q <= 5'(e_rd_q.len);
							state_q <= ST_OUT;
						end else begin
							k_q <= k_q + CW'(1);
							state_q <= ST_CREQ;
						end
					end
				end
				ST_OUT: begin
					if (!out_v_q) begin
						out_v_q <= 1'b1;
						res_found_q <= found_q;
						res_alp_q <= alp_q;
						res_mcnt_q <= mcnt_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {3'b0, res_mcnt_q, res_alp_q, res_found_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_axis_tready)
		else $error("ready high while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tdata[0] |-> (m_axis_tdata[36:1] == '0))
		else $error("miss carries nonzero fields");

endmodule
